// ===== hdl/phsd_pkg.sv =====
`default_nettype none

package phsd_pkg;

    // Defaults for the top-level parameters.
    localparam int HEADER_COUNT_MAX_DEF = 255;
    localparam int FIFO_DEPTH_DEF       = 4;

    // Register indexes on the configuration port.
    localparam logic REG_REMAP = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // Word class tags taken from the top bits of a readout word.
    localparam logic [4:0] MARKER_TAG      = 5'b11111;
    localparam logic [4:0] HEADER_TAG      = 5'b11101;
    localparam logic [2:0] DATA_HEADER_TAG = 3'b001;

    // Raw ToT codes below this value give a hit.
    localparam logic [3:0] TOT_RAW_LIMIT = 4'd13;

    typedef struct packed {
        logic [3:0]  tot;
        logic [7:0]  column;
        logic [10:0] row;
        logic [31:0] event_index;
        logic [8:0]  header_index;
        logic [7:0]  chip;
        logic        last;
    } t_hit;

    typedef struct packed {
        logic [1:0] num;
        t_hit       hit0;
        t_hit       hit1;
    } t_push;

endpackage

`default_nettype wire

// ===== hdl/phsd_hit_fifo.sv =====
`default_nettype none

module phsd_hit_fifo
    import phsd_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_push                      i_push,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output t_hit                            o_hit,
    output logic [$clog2(DEPTH + 1) - 1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_hit            r_mem [DEPTH];
    logic [PW - 1:0] r_wr;
    logic [PW - 1:0] r_rd;
    logic [CW - 1:0] r_count;
    logic [PW - 1:0] wr_next;
    logic [PW - 1:0] n_wr;
    logic [PW - 1:0] n_rd;
    logic [CW - 1:0] n_count;
    logic            pop;

    function automatic logic [PW - 1:0] ptr_inc(input logic [PW - 1:0] ptr);
        logic [PW - 1:0] res;
        if (ptr == PW'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    assign pop     = o_valid && i_ready;
    assign wr_next = ptr_inc(r_wr);
    assign o_valid = (r_count != '0);
    assign o_hit   = r_mem[r_rd];
    assign o_count = r_count;

    always_comb begin
        case (i_push.num)
            2'd1:    n_wr = wr_next;
            2'd2:    n_wr = ptr_inc(wr_next);
            default: n_wr = r_wr;
        endcase
        n_rd    = pop ? ptr_inc(r_rd) : r_rd;
        n_count = CW'(r_count + CW'(i_push.num) - CW'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.hit0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.hit1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pixel_hit_stream_decoder_top.sv =====
// Channel     | Direction | Handshake          | Payload
// ------------+-----------+--------------------+------------------------------------------
// Readout in  | input     | i_valid / o_ready  | i_action, i_raw_word, i_channel_id
// Hits out    | output    | o_valid / i_ready  | o_hit_tot .. o_last (one hit per transfer)
// Config      | input     | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// A request is taken into an input register and decoded there against the
// window state; the hits it yields (zero, one or two) drop into a small hit queue.
// A new request can be taken every cycle while the queue has room for two more hits.
// The output side drains one hit per cycle while i_ready is high, so a stream of two-hit
// records cannot be taken at the full input rate; the single hit output port sets their pace.
// Reset is synchronous and active low and clears all control state and the window state.
// Either side may stall at any time: the queue holds finished hits while the decoder works on.
`default_nettype none

module pixel_hit_stream_decoder_top
    import phsd_pkg::*;
#(
    parameter int HEADER_COUNT_MAX = HEADER_COUNT_MAX_DEF,
    parameter int FIFO_DEPTH       = FIFO_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Readout word requests.
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_action,
    input  wire logic [23:0]        i_raw_word,
    input  wire logic [7:0]         i_channel_id,
    // Decoded hits.
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [3:0]              o_hit_tot,
    output logic signed [7:0]       o_hit_column,
    output logic signed [10:0]      o_hit_row,
    output logic [31:0]             o_event_index,
    output logic signed [8:0]       o_header_index,
    output logic [7:0]              o_chip_number,
    output logic                    o_last,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // The header count holds -1 up to HEADER_COUNT_MAX, so it needs one sign bit.
    localparam int HC_W = $clog2(HEADER_COUNT_MAX + 1) + 1;
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam logic signed [HC_W - 1:0] HC_MAX = HC_W'(HEADER_COUNT_MAX);

    // Configuration registers.
    logic        r_remap;
    logic [31:0] r_limit;

    // Input register.
    logic        r_stg_vld;
    logic        r_action;
    logic [23:0] r_word;
    logic [7:0]  r_chan;

    // Window state and its next values.
    logic                     r_skip_next, n_skip_next;
    logic signed [HC_W - 1:0] r_hc, n_hc;
    logic [6:0]               r_l1_id, n_l1_id;
    logic signed [8:0]        r_bunch, n_bunch;
    logic                     r_has_hits, n_has_hits;
    logic [31:0]              r_event_count, n_event_count;
    logic [7:0]               r_chip, n_chip;

    logic            fire;
    logic            limited;
    logic            is_marker;
    logic            is_header;
    logic            is_data_header;
    logic [7:0]      bunch_next;
    logic [6:0]      word_l1;
    logic [7:0]      word_bc;
    logic [7:0]      col_m1;
    logic [9:0]      row_m1;
    logic [9:0]      row_p0;
    logic [7:0]      col_out;
    logic [10:0]     row_out0;
    logic [10:0]     row_out1;
    logic [3:0]      tot_raw0;
    logic [3:0]      tot_raw1;
    logic            tot_ok0;
    logic            tot_ok1;
    logic [HC_W + 8:0] hc_ext;
    t_hit            hit_a;
    t_hit            hit_b;
    t_push           push;
    t_hit            q_hit;
    logic [CW - 1:0] q_count;

    // The item in the input register is decoded once the queue can take two hits.
    assign fire    = r_stg_vld && (q_count <= CW'(FIFO_DEPTH - 2));
    assign o_ready = !r_stg_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else if (o_ready) begin
            r_stg_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_action <= i_action;
            r_word   <= i_raw_word;
            r_chan   <= i_channel_id;
        end
    end

    // Configuration writes and reads.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remap <= 1'b0;
            r_limit <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_REMAP: r_remap <= pwdata[0];
                REG_LIMIT: r_limit <= pwdata;
                default:   r_remap <= r_remap;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_REMAP: prdata = {31'd0, r_remap};
            REG_LIMIT: prdata = r_limit;
            default:   prdata = '0;
        endcase
    end

    // Word classification and field extraction.
    assign limited        = (r_limit != '0) && (r_event_count > r_limit);
    assign is_marker      = (r_word[23:19] == MARKER_TAG);
    assign is_header      = (r_word[23:19] == HEADER_TAG);
    assign is_data_header = (r_word[18:16] == DATA_HEADER_TAG);
    assign word_l1        = r_word[14:8];
    assign word_bc        = r_word[7:0];

    // Bunch crossing expected next; a stored 255 or -1 both roll over to zero.
    assign bunch_next = (r_bunch == 9'sd255 || r_bunch[8]) ? 8'd0 : r_bunch[7:0] + 8'd1;

    // Hit coordinates. The first hit sits one row below the second one.
    assign col_m1   = {1'b0, r_word[23:17]} - 8'd1;
    assign row_p0   = {1'b0, r_word[16:8]};
    assign row_m1   = row_p0 - 10'd1;
    assign col_out  = r_remap ? {col_m1[7], col_m1[7:1]} : col_m1;
    assign row_out0 = r_remap ? {row_m1, ~col_m1[0]} : {row_m1[9], row_m1};
    assign row_out1 = r_remap ? {row_p0, ~col_m1[0]} : {row_p0[9], row_p0};
    assign tot_raw0 = r_word[7:4];
    assign tot_raw1 = r_word[3:0];
    assign tot_ok0  = (tot_raw0 < TOT_RAW_LIMIT);
    assign tot_ok1  = (tot_raw1 < TOT_RAW_LIMIT);
    assign hc_ext   = {{9{r_hc[HC_W - 1]}}, r_hc};

    always_comb begin
        hit_a.tot          = tot_raw0 + 4'd1;
        hit_a.column       = col_out;
        hit_a.row          = row_out0;
        hit_a.event_index  = r_event_count;
        hit_a.header_index = hc_ext[8:0];
        hit_a.chip         = r_chip;
        hit_a.last         = !tot_ok1;
        hit_b              = hit_a;
        hit_b.tot          = tot_raw1 + 4'd1;
        hit_b.row          = row_out1;
        hit_b.last         = 1'b1;
    end

    // One pass of the decoder over the item in the input register.
    always_comb begin
        n_skip_next   = r_skip_next;
        n_hc          = r_hc;
        n_l1_id       = r_l1_id;
        n_bunch       = r_bunch;
        n_has_hits    = r_has_hits;
        n_event_count = r_event_count;
        n_chip        = r_chip;
        push.num      = 2'd0;
        push.hit0     = hit_a;
        push.hit1     = hit_b;

        if (fire) begin
            if (r_skip_next) begin
                // The item right after a window marker is dropped.
                n_skip_next = 1'b0;
            end else if (!limited) begin
                if (r_action) begin
                    n_chip = r_chan;
                end else if (is_marker) begin
                    // Close the window; it counts as an event only if it had hits.
                    n_skip_next = 1'b1;
                    n_hc        = '1;
                    n_bunch     = -9'sd1;
                    n_has_hits  = 1'b0;
                    if (r_has_hits) begin
                        n_event_count = r_event_count + 32'd1;
                    end
                end else if (is_header) begin
                    if (is_data_header) begin
                        n_bunch = $signed({1'b0, word_bc});
                        if (&r_hc) begin
                            n_l1_id = word_l1;
                            n_hc    = '0;
                        end else if (word_l1 == r_l1_id || word_bc == bunch_next) begin
                            if (r_hc < HC_MAX) begin
                                n_hc = r_hc + 1'b1;
                            end
                        end else begin
                            // Broken continuity: this header opens a new window.
                            n_hc       = '0;
                            n_l1_id    = word_l1;
                            n_has_hits = 1'b0;
                            if (r_has_hits) begin
                                n_event_count = r_event_count + 32'd1;
                            end
                        end
                    end
                end else begin
                    push.num = {1'b0, tot_ok0} + {1'b0, tot_ok1};
                    if (!tot_ok0) begin
                        push.hit0 = hit_b;
                    end
                    if (tot_ok0 || tot_ok1) begin
                        n_has_hits = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_next   <= 1'b0;
            r_hc          <= '1;
            r_l1_id       <= '0;
            r_bunch       <= -9'sd1;
            r_has_hits    <= 1'b0;
            r_event_count <= '0;
            r_chip        <= '0;
        end else begin
            r_skip_next   <= n_skip_next;
            r_hc          <= n_hc;
            r_l1_id       <= n_l1_id;
            r_bunch       <= n_bunch;
            r_has_hits    <= n_has_hits;
            r_event_count <= n_event_count;
            r_chip        <= n_chip;
        end
    end

    phsd_hit_fifo #(
        .DEPTH   (FIFO_DEPTH)
    ) u_hit_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hit   (q_hit),
        .o_count (q_count)
    );

    assign o_hit_tot      = q_hit.tot;
    assign o_hit_column   = $signed(q_hit.column);
    assign o_hit_row      = $signed(q_hit.row);
    assign o_event_index  = q_hit.event_index;
    assign o_header_index = $signed(q_hit.header_index);
    assign o_chip_number  = q_hit.chip;
    assign o_last         = q_hit.last;

`ifndef ASSERT_OFF
    // A swallowed item never produces hits.
    a_skip_no_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_skip_next) |-> (push.num == 2'd0))
        else $error("hits produced for a swallowed item");

    // A taken marker arms the swallow and empties the window.
    a_marker_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_skip_next && !limited && !r_action && is_marker)
        |=> (r_skip_next && !r_has_hits && (&r_hc)))
        else $error("window marker did not close the window");

    // The header count never passes its saturation value.
    a_hc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc <= HC_MAX)
        else $error("header count above its limit");

    // The hit queue never overflows.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(FIFO_DEPTH))
        else $error("hit queue overflow");

    // Of two hits from one word only the second is marked last.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num == 2'd2) |-> (push.hit1.last && !push.hit0.last))
        else $error("wrong last flag on a two-hit record");
`endif

endmodule

`default_nettype wire

// ===== tb/pixel_hit_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module pixel_hit_stream_decoder_top_tb;
    import phsd_pkg::*;

    // Run length and pacing knobs.
    localparam int CYCLE_LIMIT    = 400000;
    localparam int IDLE_TAIL      = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int HDR_MAX        = HEADER_COUNT_MAX_DEF;
    localparam int NUM_SCRIPT     = 28;

    // One readout request as the sender offers it. Rows of the directed script may carry
    // hand-written hits; those replace the decoder model's hits for that request.
    typedef struct packed {
        logic       act;
        logic [23:0] word;
        logic [7:0] chan;
        logic       typed;
        logic [1:0] n;
        t_hit       h0;
        t_hit       h1;
    } t_word_req;

    localparam t_hit NO_HIT = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [23:0] i_raw_word;
    logic [7:0]  i_channel_id;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_hit_tot;
    logic signed [7:0]  o_hit_column;
    logic signed [10:0] o_hit_row;
    logic [31:0] o_event_index;
    logic signed [8:0]  o_header_index;
    logic [7:0]  o_chip_number;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pixel_hit_stream_decoder_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_raw_word     (i_raw_word),
        .i_channel_id   (i_channel_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit_tot      (o_hit_tot),
        .o_hit_column   (o_hit_column),
        .o_hit_row      (o_hit_row),
        .o_event_index  (o_event_index),
        .o_header_index (o_header_index),
        .o_chip_number  (o_chip_number),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // The testbench's own copy of the decoder state, in reset condition at time zero.
    // The window error flag is kept for completeness even though no hit field shows it.
    bit          skip_nxt  = 1'b0;
    int          hdr_cnt   = -1;
    int          win_l1    = 0;
    int          win_bc    = -1;
    bit          win_err   = 1'b0;
    bit          win_hits  = 1'b0;
    logic [31:0] evt_cnt   = '0;
    logic [7:0]  cur_chip  = '0;
    bit          remap_on  = 1'b0;
    logic [31:0] evt_limit = '0;

    // Hits the decoder owes us, oldest first.
    t_hit        pending_hits[$];
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;

    // Request currently offered; it is updated with a nonblocking assignment together with
    // the payload so that the input monitor sees the row that belongs to the accepted word.
    t_word_req   cur_row;
    t_word_req   script_words [NUM_SCRIPT];

    bit          no_idle     = 1'b0;
    bit          rx_hold_req = 1'b0;
    int          rx_hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // A runaway run is a failure in its own right.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit log_fail();
        mismatch_cnt++;
        return mismatch_cnt <= 10;
    endfunction

    function automatic t_hit mk_hit(int tot, int col, int row, int evt, int hdr, int chip,
                                    bit fin);
        t_hit h;
        h.tot          = 4'(tot);
        h.column       = 8'(col);
        h.row          = 11'(row);
        h.event_index  = 32'(evt);
        h.header_index = 9'(hdr);
        h.chip         = 8'(chip);
        h.last         = fin;
        return h;
    endfunction

    function automatic t_word_req script_row(bit act, logic [23:0] word, logic [7:0] chan,
                                             bit typed, int n, t_hit h0, t_hit h1);
        t_word_req r;
        r.act   = act;
        r.word  = word;
        r.chan  = chan;
        r.typed = typed;
        r.n     = 2'(n);
        r.h0    = h0;
        r.h1    = h1;
        return r;
    endfunction

    // Raw ToT codes 0..13 map to 1..14, 14 maps to 0 and 15 stays 15.
    function automatic int tot_of(logic [3:0] raw);
        if (raw < 4'd14)
            return int'(raw) + 1;
        if (raw == 4'd14)
            return 0;
        return int'(raw);
    endfunction

    // Closing a window moves the event number on only if the window gave hits.
    task automatic close_win();
        if (win_hits)
            evt_cnt = evt_cnt + 32'd1;
        win_hits = 1'b0;
    endtask

    // Builds one hit, applying the interleaved remap when it is enabled. With remap on, an
    // odd column (the column of -1 included) lands on the even row of its pair.
    task automatic push_hit(int tot, int col, int row, bit fin);
        t_hit h;
        if (remap_on) begin
            if (col == -1 || col[0]) begin
                row = row * 2;
                col = (col - 1) / 2;
            end else begin
                row = row * 2 + 1;
                col = col / 2;
            end
        end
        h.tot          = 4'(tot);
        h.column       = col[7:0];
        h.row          = row[10:0];
        h.event_index  = evt_cnt;
        h.header_index = hdr_cnt[8:0];
        h.chip         = cur_chip;
        h.last         = fin;
        win_hits = 1'b1;
        pending_hits = {pending_hits, h};
    endtask

    // Decoder model: consumes one accepted request and queues the hits it yields.
    task automatic decode_readout(bit act, logic [23:0] w, logic [7:0] chan);
        int col;
        int row;
        int t0;
        int t1;
        int l1;
        int bc;
        bit ok0;
        bit ok1;
        // The request right after a window marker is dropped, whatever it is.
        if (skip_nxt) begin
            skip_nxt = 1'b0;
            return;
        end
        if (evt_limit != 32'd0 && evt_cnt > evt_limit)
            return;
        if (act) begin
            cur_chip = chan;
            return;
        end
        if (w[23:19] == MARKER_TAG) begin
            skip_nxt = 1'b1;
            hdr_cnt  = -1;
            win_bc   = -1;
            win_err  = 1'b0;
            close_win();
            return;
        end
        if (w[23:19] == HEADER_TAG) begin
            // Only data headers matter; address, value and service records fall through.
            if (w[18:16] == DATA_HEADER_TAG) begin
                l1 = int'(w[14:8]);
                bc = int'(w[7:0]);
                if (w[15])
                    win_err = 1'b1;
                if (hdr_cnt == -1) begin
                    win_l1  = l1;
                    win_bc  = bc;
                    hdr_cnt = 0;
                end else begin
                    // A bunch ID of 255 wraps so that 0 counts as its successor.
                    if (win_bc == 255)
                        win_bc = -1;
                    if (l1 == win_l1 || bc == win_bc + 1) begin
                        win_bc = bc;
                        if (hdr_cnt < HDR_MAX)
                            hdr_cnt++;
                    end else begin
                        hdr_cnt = 0;
                        win_l1  = l1;
                        win_bc  = bc;
                        win_err = 1'b0;
                        close_win();
                    end
                end
            end
            return;
        end
        col = int'(w[23:17]) - 1;
        row = int'(w[16:8]) - 1;
        t0  = tot_of(w[7:4]);
        t1  = tot_of(w[3:0]);
        ok0 = (t0 >= 1 && t0 <= 13);
        ok1 = (t1 >= 1 && t1 <= 13);
        if (ok0)
            push_hit(t0, col, row, !ok1);
        if (ok1)
            push_hit(t1, col, row + 1, 1'b1);
    endtask

    // Random request generator. Most requests form plausible windows: data headers that
    // usually continue the current window, data records in the data-record column range,
    // and markers now and then. A few percent are raw noise words.
    function automatic t_word_req rand_item(int pick);
        t_word_req r;
        int c;
        int l1;
        int bc;
        logic [3:0] n0;
        logic [3:0] n1;
        r      = '0;
        r.chan = 8'($urandom);
        r.word = 24'($urandom);
        if (pick < 6) begin
            r.act = 1'b1;
        end else if (pick < 11) begin
            r.word = {MARKER_TAG, 19'($urandom)};
        end else if (pick < 25) begin
            l1 = ($urandom_range(99) < 60) ? win_l1 : int'($urandom_range(127));
            bc = ($urandom_range(99) < 50) ? win_bc + 1 : int'($urandom_range(255));
            r.word = {HEADER_TAG, DATA_HEADER_TAG, ($urandom_range(99) < 15), 7'(l1), 8'(bc)};
        end else if (pick < 29) begin
            r.word = {HEADER_TAG, 19'($urandom)};
        end else if (pick >= 32) begin
            // Columns 116..119 and 124..127 would alias the header and marker classes.
            c = $urandom_range(119);
            if (c >= 116)
                c += 4;
            if ($urandom_range(99) < 8)
                c = 0;
            else if ($urandom_range(99) < 4)
                c = 123;
            n0 = 4'(($urandom_range(99) < 80) ? $urandom_range(13) : $urandom_range(15, 14));
            n1 = 4'(($urandom_range(99) < 80) ? $urandom_range(13) : $urandom_range(15, 14));
            r.word = {7'(c), 9'($urandom), n0, n1};
        end
        return r;
    endfunction

    // Offers one request and holds it until accepted. After acceptance the sender may
    // idle for a while; valid is lowered only then, never in a step where it is raised.
    task automatic send_item(t_word_req r);
        i_valid      <= 1'b1;
        i_action     <= r.act;
        i_raw_word   <= r.word;
        i_channel_id <= r.chan;
        cur_row      <= r;
        do @(posedge i_clk); while (!o_ready);
        if (!no_idle && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (!no_idle && $urandom_range(99) < 9);
        end
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
            send_item(rand_item($urandom_range(99)));
    endtask

    // Waits until every owed hit has come out, then lets the pipeline settle, since
    // requests that yield nothing may still be in flight. The first edge lets the input
    // monitor book the last accepted request before the queue is looked at.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(logic [2:0] addr, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            if (log_fail())
                $display("register at %0d: expected %h, got %h", addr, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes both registers, mirrors them into the model and reads them back.
    task automatic set_config(bit remap, logic [31:0] limit);
        apb_write({REG_REMAP, 2'b00}, {31'b0, remap});
        apb_write({REG_LIMIT, 2'b00}, limit);
        remap_on  = remap;
        evt_limit = limit;
        apb_read({REG_REMAP, 2'b00}, {31'b0, remap});
        apb_read({REG_LIMIT, 2'b00}, limit);
    endtask

    // Input monitor: every accepted request runs through the model. Rows of the script
    // with hand-written hits swap the model's hits for their own.
    always @(posedge i_clk) begin : in_mon
        int base;
        if (i_rst_n && i_valid && o_ready) begin
            base = pending_hits.size();
            decode_readout(i_action, i_raw_word, i_channel_id);
            if (cur_row.typed) begin
                while (pending_hits.size() > base)
                    void'(pending_hits.pop_back());
                if (cur_row.n > 0)
                    pending_hits = {pending_hits, cur_row.h0};
                if (cur_row.n > 1)
                    pending_hits = {pending_hits, cur_row.h1};
            end
        end
    end

    // Receiver: random back-pressure, a long hold-off on request, none while no_idle is set.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    // Hit checker: each accepted hit is compared field by field with the oldest owed hit.
    always @(posedge i_clk) begin : out_chk
        t_hit got;
        t_hit want;
        bit   bad;
        bit   none_owed;
        if (i_rst_n && o_valid && i_ready) begin
            got.tot          = o_hit_tot;
            got.column       = o_hit_column;
            got.row          = o_hit_row;
            got.event_index  = o_event_index;
            got.header_index = o_header_index;
            got.chip         = o_chip_number;
            got.last         = o_last;
            none_owed        = (pending_hits.size() == 0);
            if (none_owed) begin
                want = NO_HIT;
                bad  = 1'b1;
            end else begin
                want = pending_hits.pop_front();
                bad  = (got.tot !== want.tot) || (got.column !== want.column) ||
                       (got.row !== want.row) || (got.event_index !== want.event_index) ||
                       (got.header_index !== want.header_index) ||
                       (got.chip !== want.chip) || (got.last !== want.last);
            end
            if (bad && log_fail()) begin
                $display(
                    "hit%s expected tot=%0d col=%0d row=%0d evt=%0d hdr=%0d chip=%0d last=%0d",
                    none_owed ? " (none owed)" : "",
                    want.tot, $signed(want.column), $signed(want.row), want.event_index,
                    $signed(want.header_index), want.chip, want.last);
                $display(
                    "    got tot=%0d col=%0d row=%0d evt=%0d hdr=%0d chip=%0d last=%0d",
                    got.tot, $signed(got.column), $signed(got.row), got.event_index,
                    $signed(got.header_index), got.chip, got.last);
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_action     = 1'b0;
        i_raw_word   = '0;
        i_channel_id = '0;
        i_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cur_row      = '0;

        // Directed script. Rows right after reset, the field extremes and the silent cases
        // carry their hits by hand; the rest are left to the model.
        script_words = '{
            // Smallest nonzero record straight after reset: two hits, no header yet.
            script_row(0, 24'h020100, 8'h3C, 1, 2, mk_hit(1, 0, 0, 0, -1, 0, 0),
                       mk_hit(1, 0, 1, 0, -1, 0, 1)),
            // All-zero record: column and first row come out as -1.
            script_row(0, 24'h000000, 8'h00, 1, 2, mk_hit(1, -1, -1, 0, -1, 0, 0),
                       mk_hit(1, -1, 0, 0, -1, 0, 1)),
            // ToT codes 14 and 15 give no hit.
            script_row(0, 24'h0201EF, 8'hFF, 1, 0, NO_HIT, NO_HIT),
            // Raw 13 decodes to 14 and is dropped; raw 12 gives the top ToT of 13.
            script_row(0, 24'h0201DC, 8'h00, 1, 1, mk_hit(13, 0, 1, 0, -1, 0, 1), NO_HIT),
            // Largest column and row of a data record.
            script_row(0, 24'hF7FFC0, 8'h00, 1, 2, mk_hit(13, 122, 510, 0, -1, 0, 0),
                       mk_hit(1, 122, 511, 0, -1, 0, 1)),
            // Channel select with the largest chip number.
            script_row(1, 24'hFFFFFF, 8'hFF, 1, 0, NO_HIT, NO_HIT),
            // First data header of the window.
            script_row(0, 24'hE9050A, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h040255, 8'h00, 0, 0, NO_HIT, NO_HIT),
            // Continuity by level-1 ID, then by bunch crossing, then with the error bit.
            script_row(0, 24'hE9050B, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'hE9060C, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'hE98C0D, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h0A0431, 8'h00, 0, 0, NO_HIT, NO_HIT),
            // Broken continuity restarts the window and closes the old one.
            script_row(0, 24'hE92050, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h1234A7, 8'h00, 0, 0, NO_HIT, NO_HIT),
            // Header-class words that are not data headers are ignored.
            script_row(0, 24'hE80000, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'hEFFFFF, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h060300, 8'h00, 0, 0, NO_HIT, NO_HIT),
            // Marker, then a record that gets swallowed.
            script_row(0, 24'hF80000, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h020100, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h080411, 8'h00, 0, 0, NO_HIT, NO_HIT),
            // Marker, then a channel select that gets swallowed.
            script_row(0, 24'hFFFFFF, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(1, 24'h000000, 8'h55, 1, 0, NO_HIT, NO_HIT),
            // Bunch crossing 255 followed by 0 still counts as continuous.
            script_row(0, 24'hE901FF, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'hE90200, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'hAAAA5E, 8'h00, 0, 0, NO_HIT, NO_HIT),
            script_row(1, 24'h000000, 8'h00, 1, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h555555, 8'hAA, 0, 0, NO_HIT, NO_HIT),
            script_row(0, 24'h7F1FA0, 8'h00, 0, 0, NO_HIT, NO_HIT)
        };

        // Reset is applied once, at the start of the run.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plain geometry, no event limit: the directed script.
        set_config(1'b0, 32'd0);
        foreach (script_words[k])
            send_item(script_words[k]);
        wait_idle();

        // Remapped geometry. A long run of headers with one level-1 ID pushes the header
        // count into saturation, then random windows follow.
        set_config(1'b1, 32'd0);
        for (int k = 0; k < 262; k++)
            send_item(script_row(0, {HEADER_TAG, DATA_HEADER_TAG, 1'b0, 7'd42, 8'($urandom)},
                                 8'($urandom), 0, 0, NO_HIT, NO_HIT));
        send_item(rand_item(99));
        send_item(rand_item(99));
        run_random(200);
        wait_idle();

        // Event limit at the current event number: the next nonempty window close passes
        // it, the request after that marker is still swallowed, and then input is ignored.
        set_config(1'b0, evt_cnt);
        run_random(60);
        wait_idle();

        // Largest limit with remap, and a stretch with no idling on either side.
        set_config(1'b1, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        run_random(250);
        no_idle = 1'b0;
        wait_idle();

        // Back to defaults. The receiver holds off for a long stretch while the sender keeps
        // offering requests, so the hit queue fills and the input stalls. Midway the sender
        // pauses until every owed hit has come out.
        set_config(1'b0, 32'd0);
        rx_hold_req = 1'b1;
        run_random(120);
        wait_idle();
        run_random(120);
        wait_idle();

        if (pending_hits.size() != 0) begin
            mismatch_cnt += pending_hits.size();
            $display("%0d hits never came out", pending_hits.size());
        end
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
